// ===== design/gpld_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and control structs for the grid path loop detector.
package gpld_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 128;
  localparam int GRID_DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(GRID_DEPTH);

  localparam int COORD_W = 7;
  localparam int CFG_W   = 8;
  localparam int EFF_W   = $clog2(MAX_COLUMNS + 1);
  localparam int IDX_W   = COORD_W + EFF_W;
  localparam int MARK_W  = 3;

  // Reset value of the row width register after clamping.
  localparam int ROW_WIDTH_RST = 128;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [EFF_W-1:0]   eff_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [MARK_W-1:0]  mark_t;

  localparam mark_t MARK_NONE  = 3'd0;
  localparam mark_t MARK_SOUTH = 3'd2;
  localparam mark_t MARK_WEST  = 3'd3;
  localparam mark_t MARK_EAST  = 3'd4;
  localparam mark_t MARK_NORTH = 3'd5;
  localparam mark_t MARK_ROOT  = 3'd6;

  typedef enum logic [1:0] {
    ST_DONE          = 2'd0,
    ST_LOOP          = 2'd1,
    ST_NOT_COLLINEAR = 2'd2,
    ST_RANGE         = 2'd3
  } status_t;

  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_EDGE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    init_we;
    logic    in_open;
    logic    clr_start;
    logic    clr_we;
    logic    clr_step;
    logic    root_rd;
    logic    root_wr;
    logic    walk_start;
    logic    walk_rd;
    logic    walk_wr;
    logic    walk_step;
    logic    set_res;
    logic    res_hit;
    status_t res_code;
    logic    out_load;
  } gpld_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic in_fire;
    logic range_bad;
    logic is_clear;
    logic clear_empty;
    logic collinear;
    logic same_cell;
    logic clr_last;
    logic mark_hit;
    logic at_child;
    logic out_free;
  } gpld_sts_t;

  // Clamp a row width write: zero acts as one, above the grid acts as the grid.
  function automatic eff_t eff_width(input cfg_t w);
    eff_t r;
    if (w == '0) begin
      r = EFF_W'(1);
    end else if (int'(w) > MAX_COLUMNS) begin
      r = EFF_W'(MAX_COLUMNS);
    end else begin
      r = EFF_W'(w);
    end
    return r;
  endfunction

endpackage

// ===== design/gpld_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input words and the result words.
interface gpld_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  gpld_pkg::coord_t  first_x;
  gpld_pkg::coord_t  first_y;
  gpld_pkg::coord_t  second_x;
  gpld_pkg::coord_t  second_y;

  modport source (output valid, action, first_x, first_y, second_x, second_y,
                  input ready);
  modport sink   (input valid, action, first_x, first_y, second_x, second_y,
                  output ready);
endinterface

interface gpld_out_if;
  logic               valid;
  logic               ready;
  gpld_pkg::status_t  status;
  gpld_pkg::coord_t   hit_x;
  gpld_pkg::coord_t   hit_y;

  modport source (output valid, status, hit_x, hit_y, input ready);
  modport sink   (input valid, status, hit_x, hit_y, output ready);
endinterface

// ===== design/gpld_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
module gpld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/gpld_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences the sweep, clear and edge walk.
module gpld_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  gpld_pkg::gpld_sts_t sts,
  output gpld_pkg::gpld_cmd_t cmd
);
  import gpld_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EVAL, S_CLR, S_ROOT, S_RD, S_CHK, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init_we = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_open = 1'b1;
        if (sts.in_fire) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.range_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_RANGE;
          state_nxt    = S_FIN;
        end else if (sts.is_clear) begin
          if (sts.clear_empty) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_DONE;
            state_nxt    = S_FIN;
          end else begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLR;
          end
        end else begin
          cmd.root_rd = 1'b1;
          state_nxt   = S_ROOT;
        end
      end
      S_CLR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_DONE;
          state_nxt    = S_FIN;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_ROOT: begin
        // parent mark is on the read port now; rewrite to root if marked
        cmd.root_wr = 1'b1;
        if (!sts.collinear) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOT_COLLINEAR;
          state_nxt    = S_FIN;
        end else if (sts.same_cell) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_DONE;
          state_nxt    = S_FIN;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_RD;
        end
      end
      S_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if (sts.mark_hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_hit  = 1'b1;
          cmd.res_code = ST_LOOP;
          state_nxt    = S_FIN;
        end else begin
          cmd.walk_wr = 1'b1;
          if (sts.at_child) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_DONE;
            state_nxt    = S_FIN;
          end else begin
            cmd.walk_step = 1'b1;
            state_nxt     = S_RD;
          end
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

// ===== design/gpld_dp.sv =====
`timescale 1ns / 1ps
// Datapath: item registers, walk cursor, cell addressing, grid memory and output register.
module gpld_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  gpld_pkg::cfg_t      cfg_wdata,
  gpld_in_if.sink             in_chan,
  gpld_out_if.source          out_chan,
  input  gpld_pkg::gpld_cmd_t cmd,
  output gpld_pkg::gpld_sts_t sts
);
  import gpld_pkg::*;

  eff_t    eff_w_r;
  addr_t   init_cnt_r;
  logic    action_r;
  coord_t  ax_r, ay_r, bx_r, by_r;
  coord_t  cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  status_t res_status_r;
  coord_t  res_hit_x_r, res_hit_y_r;
  logic    out_valid_r;
  status_t out_status_r;
  coord_t  out_hit_x_r, out_hit_y_r;

  logic       horiz, down;
  mark_t      walk_code, wdata, rdata;
  logic       we, re;
  coord_t     sel_x, sel_y;
  logic [IDX_W-1:0] idx;
  addr_t      addr;

  function automatic logic coord_ok(input coord_t x, input coord_t y, input eff_t w);
    return (int'(x) < int'(w)) && (int'(x) < MAX_COLUMNS) && (int'(y) < MAX_ROWS);
  endfunction

  // row width and clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r    <= EFF_W'(ROW_WIDTH_RST < MAX_COLUMNS ? ROW_WIDTH_RST : MAX_COLUMNS);
      init_cnt_r <= '0;
    end else begin
      if (cfg_we) eff_w_r <= eff_width(cfg_wdata);
      if (cmd.init_we) init_cnt_r <= init_cnt_r + 1'b1;
    end
  end

  assign in_chan.ready = cmd.in_open;
  assign sts.in_fire   = in_chan.valid && cmd.in_open;

  always_ff @(posedge clk) begin
    if (sts.in_fire) begin
      action_r <= in_chan.action;
      ax_r     <= in_chan.first_x;
      ay_r     <= in_chan.first_y;
      bx_r     <= in_chan.second_x;
      by_r     <= in_chan.second_y;
    end
  end

  // walk direction from parent toward child
  assign horiz = (ay_r == by_r);
  assign down  = horiz ? (ax_r < bx_r) : (ay_r < by_r);
  always_comb begin
    if (horiz) walk_code = down ? MARK_EAST : MARK_WEST;
    else       walk_code = down ? MARK_NORTH : MARK_SOUTH;
  end

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (cmd.clr_start) begin
      cur_x_nxt = ax_r;
      cur_y_nxt = ay_r;
    end else if (cmd.clr_step) begin
      if (cur_x_r == bx_r) begin
        cur_x_nxt = ax_r;
        cur_y_nxt = cur_y_r + 1'b1;
      end else begin
        cur_x_nxt = cur_x_r + 1'b1;
      end
    end else if (cmd.walk_start) begin
      if (horiz) begin
        cur_x_nxt = down ? bx_r - 1'b1 : bx_r + 1'b1;
        cur_y_nxt = ay_r;
      end else begin
        cur_x_nxt = ax_r;
        cur_y_nxt = down ? by_r - 1'b1 : by_r + 1'b1;
      end
    end else if (cmd.walk_step) begin
      if (horiz) cur_x_nxt = down ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      else       cur_y_nxt = down ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
  end

  // cell index = y * width + x; valid coordinates never pass the grid depth
  assign sel_x = (cmd.root_rd || cmd.root_wr) ? bx_r : cur_x_r;
  assign sel_y = (cmd.root_rd || cmd.root_wr) ? by_r : cur_y_r;
  assign idx   = IDX_W'(sel_y) * IDX_W'(eff_w_r) + IDX_W'(sel_x);
  assign addr  = cmd.init_we ? init_cnt_r : ADDR_W'(idx);

  assign we = cmd.init_we || cmd.clr_we || cmd.walk_wr || (cmd.root_wr && sts.mark_hit);
  assign re = cmd.root_rd || cmd.walk_rd;

  always_comb begin
    if (cmd.root_wr)      wdata = MARK_ROOT;
    else if (cmd.walk_wr) wdata = walk_code;
    else                  wdata = MARK_NONE;
  end

  gpld_ram #(
    .WIDTH (MARK_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  assign sts.init_last   = (int'(init_cnt_r) == GRID_DEPTH - 1);
  assign sts.range_bad   = !coord_ok(ax_r, ay_r, eff_w_r) || !coord_ok(bx_r, by_r, eff_w_r);
  assign sts.is_clear    = (action_r == ACT_CLEAR);
  assign sts.clear_empty = (ax_r > bx_r) || (ay_r > by_r);
  assign sts.collinear   = (ay_r == by_r) || (ax_r == bx_r);
  assign sts.same_cell   = (ax_r == bx_r) && (ay_r == by_r);
  assign sts.clr_last    = (cur_x_r == bx_r) && (cur_y_r == by_r);
  assign sts.mark_hit    = (rdata != MARK_NONE);
  assign sts.at_child    = (cur_x_r == ax_r) && (cur_y_r == ay_r);
  assign sts.out_free    = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_code;
      res_hit_x_r  <= cmd.res_hit ? cur_x_r : '0;
      res_hit_y_r  <= cmd.res_hit ? cur_y_r : '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_hit_x_r  <= res_hit_x_r;
      out_hit_y_r  <= res_hit_y_r;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.hit_x  = out_hit_x_r;
  assign out_chan.hit_y  = out_hit_y_r;

endmodule

// ===== design/grid_path_loop_detector.sv =====
`timescale 1ns / 1ps
// Grid path loop detector: one 3-bit mark per cell of a 128 x 128 routing grid, held in a
// single-port-style RAM. After reset the block sweeps the whole grid to unmarked, one cell a
// cycle, and keeps in_chan.ready low meanwhile; row width writes are taken at any time.
// Items are then handled one at a time. A clear writes the cells of its rectangle, one RAM
// write a cycle. An edge walk needs a registered RAM read of each cell before its mark can
// be written, and ends early at the first marked cell. The result sits in an output register,
// so the next word is accepted as soon as the current result has been loaded there.
module grid_path_loop_detector (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  gpld_pkg::cfg_t cfg_wdata,
  gpld_in_if.sink        in_chan,
  gpld_out_if.source     out_chan
);
  import gpld_pkg::*;

  gpld_cmd_t cmd;
  gpld_sts_t sts;

  gpld_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  gpld_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== design/gpld_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the grid path loop detector and its bind.
module gpld_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input gpld_pkg::status_t out_status,
  input gpld_pkg::coord_t  out_hit_x,
  input gpld_pkg::coord_t  out_hit_y
);
  import gpld_pkg::*;

  // hold the result word until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_hit_x) && $stable(out_hit_y))
    else $error("result word changed while stalled");

  // the grid sweep keeps the input closed after reset
  a_init_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during grid sweep");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("input reopened or result shown right after accept");

  // hit coordinates only with a loop
  a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_LOOP) |-> (out_hit_x == '0) && (out_hit_y == '0))
    else $error("hit coordinates set without a loop");

endmodule

bind grid_path_loop_detector gpld_checker u_gpld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_hit_x  (out_chan.hit_x),
  .out_hit_y  (out_chan.hit_y)
);
